// File: rtl/core/edf_tick_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// edf tick scheduler assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef EDF_TICK_SCHEDULER_CORE_MACROS_SVH
`define EDF_TICK_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define EDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// shared constants and types of the edf tick scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int FIELD_W   = 16;
    localparam int ABS_W     = FIELD_W + 1;
    localparam int CMP_W     = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
    localparam int TIDX_W    = 4;
    localparam int CFG_W     = 5;
    localparam int TASK_ID_W = 5;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 24;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] deadline;
        logic [FIELD_W-1:0] burst;
        logic [FIELD_W-1:0] remaining;
    } tbl_entry_t;

    typedef struct packed {
        logic             we_all;
        logic             we_rem;
        logic [IDX_W-1:0] addr;
        tbl_entry_t       data;
    } tbl_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/edf_task_table.sv
// ----------------------------------------------------------------------------
// edf_task_table
// task table memory, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module edf_task_table (
    input  wire logic                     aclk,
    input  wire edf_pkg::tbl_wr_t         wr,
    input  wire logic [edf_pkg::IDX_W-1:0] rd_addr,
    output edf_pkg::tbl_entry_t           rd_data
);
    import edf_pkg::*;

    logic [FIELD_W-1:0] arrival_mem   [MAX_TASKS];
    logic [FIELD_W-1:0] deadline_mem  [MAX_TASKS];
    logic [FIELD_W-1:0] burst_mem     [MAX_TASKS];
    logic [FIELD_W-1:0] remaining_mem [MAX_TASKS];

    always_ff @(posedge aclk) begin
        if (wr.we_all) begin
            arrival_mem[wr.addr]  <= wr.data.arrival;
            deadline_mem[wr.addr] <= wr.data.deadline;
            burst_mem[wr.addr]    <= wr.data.burst;
        end
        if (wr.we_all || wr.we_rem) begin
            remaining_mem[wr.addr] <= wr.data.remaining;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data.arrival   <= arrival_mem[rd_addr];
        rd_data.deadline  <= deadline_mem[rd_addr];
        rd_data.burst     <= burst_mem[rd_addr];
        rd_data.remaining <= remaining_mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/edf_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// edf_tick_scheduler_core
// earliest-deadline-first tick scheduler over a small task table
// ----------------------------------------------------------------------------
// A load word (tuser = 0) writes one task entry and gives no result. A tick
// word (tuser = 1) scans the active entries one per cycle through a single
// compare unit: each entry is read from the table, its remaining work
// reloaded if it arrives now, and its absolute deadline checked against the
// best so far. With n the task_count capped at 16, a tick issues n reads,
// drains the registered read port and then retires into the result register,
// waiting while that register holds an untaken result; with task_count = 0
// it skips the reads and drain. The input is not ready meanwhile and is ready
// again in the cycle after the result register loads.
// The result register lets the next word be accepted while a result waits.
// task_count is taken on the cfg channel, which is always ready.
`default_nettype none

`include "edf_tick_scheduler_core_macros.svh"

module edf_tick_scheduler_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: task_index[3:0], task_arrival[19:4], task_deadline[35:20],
    //        task_burst[51:36], zero pad
    input  wire logic [edf_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: func[0]
    input  wire logic                           s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata: tick_time[15:0], task_id[20:16], zero pad
    output logic [edf_pkg::M_DATA_W-1:0]        m_tdata,
    // tuser: busy_res[0]
    output logic                                m_tuser,
    // configuration channel: task_count
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [edf_pkg::CFG_W-1:0]      cfg_data
);
    import edf_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg,     state_next;
    logic [CNT_W-1:0]     rd_idx_reg,    rd_idx_next;
    logic                 p_valid_reg,   p_valid_next;
    logic [IDX_W-1:0]     p_idx_reg,     p_idx_next;
    logic                 found_reg,     found_next;
    logic [ABS_W-1:0]     best_reg,      best_next;
    logic [IDX_W-1:0]     pick_reg,      pick_next;
    logic [FIELD_W-1:0]   pick_rem_reg,  pick_rem_next;
    logic [TIME_BITS-1:0] time_reg,      time_next;
    logic [CFG_W-1:0]     count_reg,     count_next;
    logic                 m_valid_reg,   m_valid_next;
    logic [FIELD_W-1:0]   out_time_reg,  out_time_next;
    logic                 out_busy_reg,  out_busy_next;
    logic [TASK_ID_W-1:0] out_id_reg,    out_id_next;

    // input word fields
    logic                 in_func;
    logic [TIDX_W-1:0]    in_index;
    logic [FIELD_W-1:0]   in_arrival, in_deadline, in_burst;
    logic                 s_fire;

    // table access
    tbl_wr_t              tbl_wr;
    logic [IDX_W-1:0]     tbl_rd_addr;
    tbl_entry_t           tbl_rd;

    // shared compare unit
    logic [CNT_W-1:0]     n_active;
    logic [CMP_W-1:0]     time_ext, arr_ext;
    logic                 arr_hit, arr_past, elig, better;
    logic [FIELD_W-1:0]   rem_eff;
    logic [ABS_W-1:0]     abs_dl;
    logic                 finish_go;

    assign in_func     = s_tuser;
    assign in_index    = s_tdata[3:0];
    assign in_arrival  = s_tdata[19:4];
    assign in_deadline = s_tdata[35:20];
    assign in_burst    = s_tdata[51:36];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_busy_reg;
    assign m_tdata  = {{(M_DATA_W - FIELD_W - TASK_ID_W){1'b0}}, out_id_reg, out_time_reg};

    // task_count above the table depth acts as the depth
    assign n_active = (32'(count_reg) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(count_reg);

    // per-entry evaluation of the word coming out of the table read port
    assign time_ext = CMP_W'(time_reg);
    assign arr_ext  = CMP_W'(tbl_rd.arrival);
    assign arr_hit  = (arr_ext == time_ext);
    assign arr_past = (arr_ext <= time_ext);
    assign rem_eff  = arr_hit ? tbl_rd.burst : tbl_rd.remaining;
    assign elig     = arr_past && (rem_eff != '0);
    assign abs_dl   = ABS_W'(tbl_rd.arrival) + ABS_W'(tbl_rd.deadline);
    // strict less-than keeps the lowest index on a tie
    assign better   = elig && (!found_reg || (abs_dl < best_reg));

    // result register free, tick can retire
    assign finish_go = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    edf_task_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd)
    );

    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        p_valid_next  = 1'b0;
        p_idx_next    = p_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        pick_rem_next = pick_rem_reg;
        time_next     = time_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        out_time_next = out_time_reg;
        out_busy_next = out_busy_reg;
        out_id_next   = out_id_reg;

        tbl_rd_addr         = rd_idx_reg[IDX_W-1:0];
        tbl_wr.we_all       = 1'b0;
        tbl_wr.we_rem       = 1'b0;
        tbl_wr.addr         = p_idx_reg;
        tbl_wr.data         = '{arrival: in_arrival, deadline: in_deadline,
                                burst: in_burst, remaining: rem_eff};

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end

        // result taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // table pipeline stage: reload and compare one entry
        if (p_valid_reg) begin
            tbl_wr.we_rem = 1'b1;
            if (better) begin
                found_next    = 1'b1;
                best_next     = abs_dl;
                pick_next     = p_idx_reg;
                pick_rem_next = rem_eff;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (in_func == FUNC_LOAD) begin
                        // loads to an index past the table are dropped
                        if (32'(in_index) < MAX_TASKS) begin
                            tbl_wr.we_all         = 1'b1;
                            tbl_wr.addr           = IDX_W'(in_index);
                            tbl_wr.data.remaining = in_burst;
                        end
                    end else begin
                        found_next  = 1'b0;
                        rd_idx_next = '0;
                        state_next  = (n_active == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue one table read per cycle
                p_valid_next = 1'b1;
                p_idx_next   = rd_idx_reg[IDX_W-1:0];
                rd_idx_next  = rd_idx_reg + 1'b1;
                if (rd_idx_next == n_active) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last entry is in the compare stage this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (finish_go) begin
                    if (found_reg) begin
                        tbl_wr.we_rem         = 1'b1;
                        tbl_wr.addr           = pick_reg;
                        tbl_wr.data.remaining = pick_rem_reg - 1'b1;
                    end
                    m_valid_next  = 1'b1;
                    out_time_next = time_ext[FIELD_W-1:0];
                    out_busy_next = found_reg;
                    out_id_next   = found_reg ? TASK_ID_W'(32'(pick_reg) + 1) : '0;
                    // time saturates at all ones
                    if (time_reg != {TIME_BITS{1'b1}}) begin
                        time_next = time_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            time_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            found_reg   <= found_next;
            time_reg    <= time_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        p_idx_reg    <= p_idx_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        pick_rem_reg <= pick_rem_next;
        out_time_reg <= out_time_next;
        out_busy_reg <= out_busy_next;
        out_id_reg   <= out_id_next;
    end

    // a tick leaves the idle state, for the scan or, with no active tasks, for finish
    `EDF_ASSERT_NEXT(a_tick_starts_scan, s_fire && (in_func == FUNC_TICK), state_reg != ST_IDLE, "tick word did not start a scan")

    // the compare stage only runs inside a scan
    `EDF_ASSERT_SAME(a_pipe_in_scan, p_valid_reg, (state_reg == ST_DRAIN) || (state_reg == ST_SCAN), "compare stage active outside a scan")

    // the picked task lies inside the active range and still has work
    `EDF_ASSERT_SAME(a_pick_in_range, (state_reg == ST_FINISH) && found_reg, (CNT_W'(pick_reg) < n_active) && (pick_rem_reg != '0), "picked task outside active range or without work")

endmodule

`default_nettype wire
